// ===== hdl/itrd_pkg.sv =====
// Shared widths, limits and the digit-to-ASCII mapping for the radix digit converter.
`default_nettype none

package itrd_pkg;

    // Field widths of the request and result channels.
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    // Default sizing of the converter.
    localparam int DIGIT_SLOTS_DEF = 64;
    localparam int VALUE_BITS_DEF  = 64;

    // Legal number bases.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // ASCII codes used to build characters.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

    // Map a digit value to its lower-case ASCII character.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_DIGITS) begin
            c = CHAR_ZERO + {1'b0, d};
        end else if (d <= RADIX_MAX - 6'd1) begin
            c = CHAR_LOW_A + {1'b0, d - DECIMAL_DIGITS};
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/itrd_if.sv =====
// Valid/ready channel interfaces for conversion requests and character results.
`default_nettype none

interface itrd_in_if;
    logic                               valid;
    logic                               ready;
    logic [itrd_pkg::VALUE_W-1:0]       value;
    logic [itrd_pkg::RADIX_W-1:0]       radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itrd_out_if;
    logic                               valid;
    logic                               ready;
    logic [itrd_pkg::CHAR_W-1:0]        character;
    logic                               last;
    logic                               bad_radix;

    modport source (output valid, output character, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last, input bad_radix,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/itrd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/integer_to_radix_digits_core.sv =====
// Top level: converts an unsigned value to lower-case ASCII digits in a given base.
//
//  Channel  Direction  Payload                        Handshake
//  i_req    in         value[63:0], radix[5:0]        valid/ready, sink
//  o_rsp    out        character[6:0], last, bad_radix valid/ready, source
//
// A nonzero value with a legal base is divided one digit at a time in the shared
// bit-serial divider; each character then passes the RAM read, load and hand-over
// states, and the sink can stall the hand-over.
// A zero value or an illegal base gives one character. One request is in flight at a time:
// i_req.ready is high only when idle. Reset is synchronous and active low; the digit
// RAM needs no clearing because only entries written by the current request are read.
`default_nettype none

module integer_to_radix_digits_core #(
    parameter int DIGIT_SLOTS = itrd_pkg::DIGIT_SLOTS_DEF,
    parameter int VALUE_BITS  = itrd_pkg::VALUE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itrd_in_if.sink     i_req,
    itrd_out_if.source  o_rsp
);

    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int DW    = itrd_pkg::DIGIT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_LOAD = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [VALUE_BITS-1:0]           r_quo, n_quo;
    logic [DW-1:0]                   r_rem, n_rem;
    logic [itrd_pkg::RADIX_W-1:0]    r_radix, n_radix;
    logic [BIT_W-1:0]                r_bit, n_bit;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [IDX_W-1:0]                r_ptr, n_ptr;
    logic                            r_out_valid, n_out_valid;
    logic [itrd_pkg::CHAR_W-1:0]     r_out_char, n_out_char;
    logic                            r_out_last, n_out_last;
    logic                            r_out_bad, n_out_bad;

    logic [VALUE_BITS-1:0]           req_value;
    logic                            radix_ok;
    logic [DW:0]                     trial;
    logic [DW:0]                     diff;
    logic                            quo_bit;
    logic [DW-1:0]                   rem_step;
    logic [VALUE_BITS-1:0]           quo_step;
    logic [CNT_W-1:0]                cnt_inc;

    logic                            ram_wr_en;
    logic                            ram_rd_en;
    logic [DW-1:0]                   ram_rd_data;

    // Request decode.
    assign req_value = i_req.value[VALUE_BITS-1:0];
    assign radix_ok  = i_req.radix inside {[itrd_pkg::RADIX_MIN : itrd_pkg::RADIX_MAX]};

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign trial    = {r_rem, r_quo[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, r_radix};
    assign quo_bit  = (trial >= {1'b0, r_radix});
    assign rem_step = quo_bit ? diff[DW-1:0] : trial[DW-1:0];
    assign quo_step = {r_quo[VALUE_BITS-2:0], quo_bit};
    assign cnt_inc  = r_cnt + CNT_W'(1);

    // The remainder of each finished digit goes into the RAM at the digit count.
    assign ram_wr_en = (r_state == S_DIV) && (r_bit == '0);
    assign ram_rd_en = (r_state == S_READ);

    itrd_ram #(
        .WIDTH (DW),
        .DEPTH (DIGIT_SLOTS)
    ) u_digit_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_cnt[IDX_W-1:0]),
        .i_wr_data (rem_step),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (ram_rd_data)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_quo   = req_value;
                    n_rem   = '0;
                    n_radix = i_req.radix;
                    n_bit   = BIT_W'(VALUE_BITS - 1);
                    n_cnt   = '0;
                    if (req_value == '0) begin
                        // Zero converts to the single character '0'.
                        n_out_valid = 1'b1;
                        n_out_char  = itrd_pkg::CHAR_ZERO;
                        n_out_last  = 1'b1;
                        n_out_bad   = 1'b0;
                        n_state     = S_EMIT;
                    end else if (!radix_ok) begin
                        n_out_valid = 1'b1;
                        n_out_char  = itrd_pkg::CHAR_NONE;
                        n_out_last  = 1'b1;
                        n_out_bad   = 1'b1;
                        n_state     = S_EMIT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_quo = quo_step;
                n_rem = rem_step;
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    // Digit done: stop when the quotient is zero or the store is full.
                    n_cnt = cnt_inc;
                    n_rem = '0;
                    n_bit = BIT_W'(VALUE_BITS - 1);
                    if ((quo_step == '0) || (cnt_inc == CNT_W'(DIGIT_SLOTS))) begin
                        n_ptr   = r_cnt[IDX_W-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_out_char  = itrd_pkg::digit_to_char(ram_rd_data);
                n_out_last  = (r_ptr == '0);
                n_out_bad   = 1'b0;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (o_rsp.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_quo       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_quo       <= n_quo;
        end
    end

    // Datapath and result payload registers.
    always_ff @(posedge i_clk) begin
        r_radix    <= n_radix;
        r_bit      <= n_bit;
        r_ptr      <= n_ptr;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    // Channel outputs.
    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.character = r_out_char;
    assign o_rsp.last      = r_out_last;
    assign o_rsp.bad_radix = r_out_bad;

endmodule

`default_nettype wire
